@@ rtl/rdlfe_pkg.sv @@
package rdlfe_pkg;

    localparam int MAX_RULES_DEF  = 16;
    localparam int POS_BITS_DEF   = 12;

    localparam int FIELD_W        = 12;
    localparam int RULE_W         = 5;
    localparam int INDEX_W        = 4;
    localparam int CHAR_W         = 8;
    localparam int KIND_W         = 2;
    localparam int RULE_BITS      = 10;
    localparam int RULE_WORDS     = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 40;

    typedef logic [1:0] t_action;
    localparam t_action ACT_UPTO   = 2'd0;
    localparam t_action ACT_SKIPTO = 2'd1;
    localparam t_action ACT_SKIP   = 2'd2;
    localparam t_action ACT_ANY    = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIELD  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_WORD_3 = 3'd4;

    typedef logic [2:0] t_upc;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CHECK = 3'd1,
        OP_RULE  = 3'd2,
        OP_FLUSH = 3'd3,
        OP_EOL   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        COND_NEVER = 2'd0,
        COND_EOL   = 2'd1,
        COND_STOP  = 2'd2,
        COND_MORE  = 2'd3
    } t_cond;

    typedef struct packed {
        logic  take_in;
        t_op   op;
        t_cond cond;
        t_upc  target;
        t_upc  seq_next;
    } t_uword;

    typedef struct packed {
        logic hold;
        logic eol;
        logic stop;
        logic more;
    } t_ustat;

endpackage

@@ rtl/rdlfe_useq.sv @@
module rdlfe_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdlfe_pkg::t_ustat i_stat,
    output rdlfe_pkg::t_uword o_uword
);

    localparam rdlfe_pkg::t_upc UPC_FETCH = 3'd0;
    localparam rdlfe_pkg::t_upc UPC_CHECK = 3'd1;
    localparam rdlfe_pkg::t_upc UPC_RULE  = 3'd2;
    localparam rdlfe_pkg::t_upc UPC_FLUSH = 3'd3;
    localparam rdlfe_pkg::t_upc UPC_EOL   = 3'd4;

    // control store: take_in, op, cond, target, seq_next
    function automatic rdlfe_pkg::t_uword urom(input rdlfe_pkg::t_upc pc);
        rdlfe_pkg::t_uword w;
        w = '{1'b0, rdlfe_pkg::OP_NONE, rdlfe_pkg::COND_NEVER, UPC_FETCH, UPC_FETCH};
        unique case (pc)
            UPC_FETCH: w = '{1'b1, rdlfe_pkg::OP_NONE,  rdlfe_pkg::COND_EOL,
                             UPC_EOL, UPC_CHECK};
            UPC_CHECK: w = '{1'b0, rdlfe_pkg::OP_CHECK, rdlfe_pkg::COND_STOP,
                             UPC_FETCH, UPC_RULE};
            UPC_RULE:  w = '{1'b0, rdlfe_pkg::OP_RULE,  rdlfe_pkg::COND_MORE,
                             UPC_RULE, UPC_FLUSH};
            UPC_FLUSH: w = '{1'b0, rdlfe_pkg::OP_FLUSH, rdlfe_pkg::COND_NEVER,
                             UPC_FETCH, UPC_FETCH};
            UPC_EOL:   w = '{1'b0, rdlfe_pkg::OP_EOL,   rdlfe_pkg::COND_NEVER,
                             UPC_FETCH, UPC_FETCH};
            default: ;
        endcase
        return w;
    endfunction

    rdlfe_pkg::t_upc r_upc;
    rdlfe_pkg::t_upc n_upc;
    logic            jump;

    assign o_uword = urom(r_upc);

    always_comb begin
        unique case (o_uword.cond)
            rdlfe_pkg::COND_NEVER: jump = 1'b0;
            rdlfe_pkg::COND_EOL:   jump = i_stat.eol;
            rdlfe_pkg::COND_STOP:  jump = i_stat.stop;
            rdlfe_pkg::COND_MORE:  jump = i_stat.more;
            default:               jump = 1'b0;
        endcase
        if (i_stat.hold) begin
            n_upc = r_upc;
        end else if (jump) begin
            n_upc = o_uword.target;
        end else begin
            n_upc = o_uword.seq_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

@@ rtl/rule_driven_line_field_extractor.sv @@
// Rule-driven line field extractor. Characters of a line arrive one per input
// transaction, closed by an end-of-line transaction; a program of up to
// MAX_RULES rules (to be set through the configuration port while idle; the
// block does not enforce this) walks the line and emits one result per
// completed capture and one accept/reject verdict per line, is_last marking
// the final result of each transaction. A microcoded sequencer steps a single
// rule evaluator: a character passes fetch, check, rule passes until no
// delimiter matches, and flush; an overlong-line character returns from check
// to fetch, end of line to the verdict; output stalls hold any emitting step.
module rule_driven_line_field_extractor #(
    parameter int MAX_RULES = rdlfe_pkg::MAX_RULES_DEF,
    parameter int POS_BITS  = rdlfe_pkg::POS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [rdlfe_pkg::CHAR_W-1:0]     i_char_code,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rdlfe_pkg::KIND_W-1:0]     o_result_kind,
    output logic [rdlfe_pkg::INDEX_W-1:0]    o_field_index,
    output logic [rdlfe_pkg::FIELD_W-1:0]    o_field_start,
    output logic [rdlfe_pkg::FIELD_W-1:0]    o_field_length,
    output logic                             o_is_last,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rdlfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdlfe_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FW = rdlfe_pkg::FIELD_W;
    localparam int RW = rdlfe_pkg::RULE_W;

    function automatic logic [FW-1:0] to_field(input logic [POS_BITS-1:0] p);
        logic [POS_BITS+FW-1:0] wide;
        wide = {{FW{1'b0}}, p};
        return wide[FW-1:0];
    endfunction

    rdlfe_pkg::t_uword uw;
    rdlfe_pkg::t_ustat stat;

    logic [rdlfe_pkg::CHAR_W-1:0]     r_char;
    logic [RW-1:0]                    r_rule_count;
    logic [rdlfe_pkg::CFG_DATA_W-1:0] r_rule_word [rdlfe_pkg::RULE_WORDS];
    logic [RW-1:0]                    r_rule;
    logic [POS_BITS-1:0]              r_pos;
    logic [POS_BITS-1:0]              r_cb;
    logic                             r_failed;
    logic                             r_ovf;

    logic                             r_pend_valid;
    logic [rdlfe_pkg::INDEX_W-1:0]    r_pend_index;
    logic [FW-1:0]                    r_pend_start;
    logic [FW-1:0]                    r_pend_length;

    logic                             r_out_valid;
    rdlfe_pkg::t_kind                 r_out_kind;
    logic [rdlfe_pkg::INDEX_W-1:0]    r_out_index;
    logic [FW-1:0]                    r_out_start;
    logic [FW-1:0]                    r_out_length;
    logic                             r_out_last;

    logic [RW-1:0]                    act_count;
    logic [rdlfe_pkg::RULE_BITS-1:0]  rule_bits;
    rdlfe_pkg::t_action               act;
    logic [rdlfe_pkg::CHAR_W-1:0]     rule_char;
    logic                             live;
    logic                             hit;
    logic                             rule_more;
    logic                             rule_cap;
    logic                             out_free;
    logic                             need_out;
    logic                             hold;
    logic                             step;
    logic [POS_BITS-1:0]              pos_inc;
    logic [POS_BITS-1:0]              cap_len;
    logic                             verdict_ok;
    logic [1:0]                       cfg_word;

    logic                             push;
    rdlfe_pkg::t_kind                 push_kind;
    logic [rdlfe_pkg::INDEX_W-1:0]    push_index;
    logic [FW-1:0]                    push_start;
    logic [FW-1:0]                    push_length;
    logic                             push_last;

    rdlfe_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    assign act_count = (r_rule_count > RW'(MAX_RULES)) ? RW'(MAX_RULES) : r_rule_count;
    assign rule_bits = r_rule_word[r_rule[3:2]][r_rule[1:0]*rdlfe_pkg::RULE_BITS +:
                                                 rdlfe_pkg::RULE_BITS];
    assign act       = rule_bits[9:8];
    assign rule_char = rule_bits[7:0];
    assign live      = !r_failed && (r_rule < act_count);
    assign hit       = (r_char == rule_char);
    assign rule_more = live && hit &&
                       ((act == rdlfe_pkg::ACT_UPTO) || (act == rdlfe_pkg::ACT_SKIPTO));
    assign rule_cap  = rule_more && (act == rdlfe_pkg::ACT_UPTO);
    assign pos_inc   = r_pos + 1'b1;
    assign cap_len   = r_pos - r_cb;
    assign verdict_ok = !r_failed && !r_ovf && (r_rule >= act_count);
    assign cfg_word  = 2'(i_cfg_index - rdlfe_pkg::CFG_RULE_WORD_0);

    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (uw.op)
            rdlfe_pkg::OP_RULE:  need_out = rule_cap && r_pend_valid;
            rdlfe_pkg::OP_FLUSH: need_out = r_pend_valid;
            rdlfe_pkg::OP_EOL:   need_out = 1'b1;
            rdlfe_pkg::OP_NONE,
            rdlfe_pkg::OP_CHECK: need_out = 1'b0;
            default:             need_out = 1'b0;
        endcase
    end

    assign hold = (uw.take_in && !i_in_valid) || (need_out && !out_free);
    assign step = !hold;
    assign push = step && need_out;

    assign stat.hold = hold;
    assign stat.eol  = i_command;
    assign stat.stop = r_ovf || (&r_pos);
    assign stat.more = rule_more;

    always_comb begin
        push_kind   = rdlfe_pkg::KIND_FIELD;
        push_index  = r_pend_index;
        push_start  = r_pend_start;
        push_length = r_pend_length;
        push_last   = (uw.op == rdlfe_pkg::OP_FLUSH);
        if (uw.op == rdlfe_pkg::OP_EOL) begin
            push_kind   = verdict_ok ? rdlfe_pkg::KIND_ACCEPT : rdlfe_pkg::KIND_REJECT;
            push_index  = '0;
            push_start  = '0;
            push_length = '0;
            push_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_count <= '0;
            for (int w = 0; w < rdlfe_pkg::RULE_WORDS; w++) begin
                r_rule_word[w] <= '0;
            end
            r_rule       <= '0;
            r_pos        <= '0;
            r_cb         <= '0;
            r_failed     <= 1'b0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == rdlfe_pkg::CFG_RULE_COUNT) begin
                    r_rule_count <= i_cfg_data[RW-1:0];
                end else if (i_cfg_index >= rdlfe_pkg::CFG_RULE_WORD_0 &&
                             i_cfg_index <= rdlfe_pkg::CFG_RULE_WORD_3) begin
                    r_rule_word[cfg_word] <= i_cfg_data;
                end
            end

            if (uw.take_in && i_in_valid) begin
                r_char <= i_char_code;
            end

            if (push) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= push_kind;
                r_out_index  <= push_index;
                r_out_start  <= push_start;
                r_out_length <= push_length;
                r_out_last   <= push_last;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end

            if (step) begin
                unique case (uw.op)
                    rdlfe_pkg::OP_CHECK: begin
                        if (stat.stop) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    rdlfe_pkg::OP_RULE: begin
                        if (rule_more) begin
                            // delimiter stays for the next rule
                            r_rule <= r_rule + 1'b1;
                            r_cb   <= r_pos;
                            if (rule_cap) begin
                                r_pend_valid  <= 1'b1;
                                r_pend_index  <= r_rule[rdlfe_pkg::INDEX_W-1:0];
                                r_pend_start  <= to_field(r_cb);
                                r_pend_length <= to_field(cap_len);
                            end
                        end else begin
                            r_pos <= pos_inc;
                            if (live) begin
                                if (act == rdlfe_pkg::ACT_ANY ||
                                    (act == rdlfe_pkg::ACT_SKIP && hit)) begin
                                    r_rule <= r_rule + 1'b1;
                                    r_cb   <= pos_inc;
                                end else if (act == rdlfe_pkg::ACT_SKIP) begin
                                    r_failed <= 1'b1;
                                end
                            end
                        end
                    end
                    rdlfe_pkg::OP_FLUSH: begin
                        r_pend_valid <= 1'b0;
                    end
                    rdlfe_pkg::OP_EOL: begin
                        r_rule   <= '0;
                        r_pos    <= '0;
                        r_cb     <= '0;
                        r_failed <= 1'b0;
                        r_ovf    <= 1'b0;
                    end
                    rdlfe_pkg::OP_NONE: ;
                    default: ;
                endcase
            end
        end
    end

    assign o_in_stall     = !uw.take_in;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_field_index  = r_out_index;
    assign o_field_start  = r_out_start;
    assign o_field_length = r_out_length;
    assign o_is_last      = r_out_last;

`ifndef ASSERT_OFF
    a_pend_empty_at_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uw.take_in |-> !r_pend_valid)
        else $error("capture still pending when next transaction is taken");

    a_eol_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == rdlfe_pkg::OP_EOL && step) |=>
            (r_rule == '0 && r_pos == '0 && !r_failed && !r_ovf))
        else $error("line state not cleared after verdict");

    a_verdict_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != rdlfe_pkg::KIND_FIELD) |-> r_out_last)
        else $error("verdict without is_last");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int FIELD_W       = rdlfe_pkg::FIELD_W;
    localparam int CFG_IDX_W     = rdlfe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = rdlfe_pkg::CFG_DATA_W;
    localparam int INDEX_W       = rdlfe_pkg::INDEX_W;
    localparam int CHAR_W        = rdlfe_pkg::CHAR_W;
    localparam int KIND_W        = rdlfe_pkg::KIND_W;
    localparam int RULE_W        = rdlfe_pkg::RULE_W;
    localparam int RULE_BITS     = rdlfe_pkg::RULE_BITS;
    localparam int RULE_WORDS    = rdlfe_pkg::RULE_WORDS;
    localparam int MAX_RULES_DEF = rdlfe_pkg::MAX_RULES_DEF;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;
    localparam logic [FIELD_W-1:0] POS_LAST = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = rdlfe_pkg::CFG_RULE_WORD_3 + 3'd1;
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        rdlfe_pkg::t_kind   kind;
        logic [INDEX_W-1:0] index;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_command = CMD_CHAR;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [KIND_W-1:0]     o_result_kind;
    logic [INDEX_W-1:0]    o_field_index;
    logic [FIELD_W-1:0]    o_field_start;
    logic [FIELD_W-1:0]    o_field_length;
    logic                  o_is_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // configuration copy and line state of the predictor
    logic [RULE_W-1:0]     cfg_count = '0;
    logic [CFG_DATA_W-1:0] cfg_words [RULE_WORDS];
    logic [RULE_W-1:0]     cur_rule = '0;
    logic [FIELD_W-1:0]    ln_pos = '0;
    logic [FIELD_W-1:0]    cap_begin = '0;
    logic                  ln_failed = 1'b0;
    logic                  ln_overflow = 1'b0;

    t_result    due_results [$];
    logic [8:0] line_items [$];

    int errors = 0;
    int items_sent = 0;
    int n_fields = 0;
    int n_accepts = 0;
    int n_rejects = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int quiet_cycles = 0;

    rule_driven_line_field_extractor i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_field_index  (o_field_index),
        .o_field_start  (o_field_start),
        .o_field_length (o_field_length),
        .o_is_last      (o_is_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    function automatic void add_due(input t_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void add_line_item(input logic [8:0] it);
        line_items.insert(line_items.size(), it);
    endfunction

    function automatic logic [RULE_BITS-1:0] rule_at(input logic [3:0] idx);
        return cfg_words[idx[3:2]][idx[1:0]*RULE_BITS +: RULE_BITS];
    endfunction

    function automatic logic [RULE_BITS-1:0] rule_code(input rdlfe_pkg::t_action act,
                                                       input logic [7:0] ch);
        return {act, ch};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_rules(
        input logic [RULE_BITS-1:0] r0, input logic [RULE_BITS-1:0] r1,
        input logic [RULE_BITS-1:0] r2, input logic [RULE_BITS-1:0] r3);
        return {r3, r2, r1, r0};
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] ch);
        return ch ^ 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(5))
            0: return 8'h2C;
            1: return 8'h3B;
            2: return 8'h20;
            3: return 8'h7C;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        if (idx == rdlfe_pkg::CFG_RULE_COUNT) begin
            cfg_count = data[RULE_W-1:0];
        end else if (idx <= rdlfe_pkg::CFG_RULE_WORD_3) begin
            cfg_words[2'(idx - rdlfe_pkg::CFG_RULE_WORD_0)] = data;
        end
    endtask

    // expected results of one accepted transaction
    task automatic walk_rules(input logic cmd, input logic [7:0] ch);
        t_result              found [MAX_RULES_DEF];
        t_result              verdict;
        logic [RULE_W-1:0]    limit;
        logic [RULE_BITS-1:0] rule;
        rdlfe_pkg::t_action   act;
        logic                 consumed;
        int                   n;
        n = 0;
        consumed = 1'b0;
        limit = (cfg_count > RULE_W'(MAX_RULES_DEF)) ? RULE_W'(MAX_RULES_DEF) : cfg_count;
        if (cmd == CMD_EOL) begin
            verdict = '0;
            verdict.kind = (!ln_failed && !ln_overflow && cur_rule >= limit) ?
                           rdlfe_pkg::KIND_ACCEPT : rdlfe_pkg::KIND_REJECT;
            verdict.last = 1'b1;
            add_due(verdict);
            cur_rule = '0;
            ln_pos = '0;
            cap_begin = '0;
            ln_failed = 1'b0;
            ln_overflow = 1'b0;
            return;
        end
        if (ln_overflow) return;
        if (ln_pos == POS_LAST) begin
            ln_overflow = 1'b1;
            return;
        end
        while (!consumed && !ln_failed && cur_rule < limit) begin
            rule = rule_at(cur_rule[3:0]);
            act = rule[9:8];
            if (act == rdlfe_pkg::ACT_SKIP && ch != rule[7:0]) begin
                ln_failed = 1'b1;
            end else if (act == rdlfe_pkg::ACT_SKIP || act == rdlfe_pkg::ACT_ANY) begin
                consumed = 1'b1;
                ln_pos = ln_pos + 12'd1;
                cur_rule = cur_rule + 5'd1;
                cap_begin = ln_pos;
            end else if (ch != rule[7:0]) begin
                consumed = 1'b1;
                ln_pos = ln_pos + 12'd1;
            end else begin
                if (act == rdlfe_pkg::ACT_UPTO) begin
                    found[n] = '0;
                    found[n].kind = rdlfe_pkg::KIND_FIELD;
                    found[n].index = cur_rule[3:0];
                    found[n].start = cap_begin;
                    found[n].length = ln_pos - cap_begin;
                    n++;
                end
                cur_rule = cur_rule + 5'd1;
                cap_begin = ln_pos;
            end
        end
        if (!consumed) ln_pos = ln_pos + 12'd1;
        for (int k = 0; k < n; k++) begin
            found[k].last = (k == n - 1);
            add_due(found[k]);
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) walk_rules(i_command, i_char_code);
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual kind %0d index %0d",
                             $time, o_result_kind, o_field_index);
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", int'(want.kind), int'(o_result_kind));
                    check_field("field_index", int'(want.index), int'(o_field_index));
                    check_field("field_start", int'(want.start), int'(o_field_start));
                    check_field("field_length", int'(want.length), int'(o_field_length));
                    check_field("is_last", int'(want.last), int'(o_is_last));
                    if (want.kind == rdlfe_pkg::KIND_FIELD) n_fields++;
                    else if (want.kind == rdlfe_pkg::KIND_ACCEPT) n_accepts++;
                    else n_rejects++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] ch);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_char_code <= ch;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) send_item(CMD_CHAR, text[k]);
    endtask

    task automatic end_line();
        send_item(CMD_EOL, 8'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_program(input logic [RULE_W-1:0] count,
                                input logic [CFG_DATA_W-1:0] w0,
                                input logic [CFG_DATA_W-1:0] w1,
                                input logic [CFG_DATA_W-1:0] w2,
                                input logic [CFG_DATA_W-1:0] w3);
        write_reg(rdlfe_pkg::CFG_RULE_WORD_0, w0);
        write_reg(rdlfe_pkg::CFG_RULE_WORD_0 + 3'd1, w1);
        write_reg(rdlfe_pkg::CFG_RULE_WORD_0 + 3'd2, w2);
        write_reg(rdlfe_pkg::CFG_RULE_WORD_3, w3);
        write_reg(rdlfe_pkg::CFG_RULE_COUNT, {{(CFG_DATA_W-RULE_W){1'b0}}, count});
    endtask

    task automatic load_random_program();
        logic [CFG_DATA_W-1:0] words [RULE_WORDS];
        logic [RULE_W-1:0]     count;
        int                    pick;
        pick = $urandom_range(99);
        if (pick < 10) count = '0;
        else if (pick < 25) count = RULE_W'(MAX_RULES_DEF);
        else if (pick < 30) count = RULE_W'($urandom_range(17, 31));
        else count = RULE_W'($urandom_range(1, 8));
        for (int w = 0; w < RULE_WORDS; w++) begin
            if ($urandom_range(9) == 0) begin
                words[w] = {8'($urandom), $urandom};
            end else begin
                for (int k = 0; k < 4; k++)
                    words[w][k*RULE_BITS +: RULE_BITS] =
                        rule_code(2'($urandom_range(3)), pick_char());
            end
        end
        load_program(count, words[0], words[1], words[2], words[3]);
    endtask

    // mostly lines that follow the program, some random, cut short or with a bad skip char
    task automatic build_line();
        logic [RULE_BITS-1:0] rule;
        logic [7:0]           pend;
        logic                 has_pend;
        int                   limit;
        int                   cut;
        line_items.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(0, 12)) add_line_item({CMD_CHAR, 8'($urandom)});
            return;
        end
        limit = (cfg_count > RULE_W'(MAX_RULES_DEF)) ? MAX_RULES_DEF : int'(cfg_count);
        cut = ($urandom_range(99) < 8) ? $urandom_range(0, limit) : limit;
        has_pend = 1'b0;
        pend = '0;
        for (int r = 0; r < cut; r++) begin
            rule = rule_at(4'(r));
            if (rule[9:8] == rdlfe_pkg::ACT_SKIP || rule[9:8] == rdlfe_pkg::ACT_ANY) begin
                if (!has_pend) begin
                    if (rule[9:8] == rdlfe_pkg::ACT_ANY)
                        add_line_item({CMD_CHAR, 8'($urandom)});
                    else if ($urandom_range(99) < 5)
                        add_line_item({CMD_CHAR, other_than(rule[7:0])});
                    else add_line_item({CMD_CHAR, rule[7:0]});
                end
                has_pend = 1'b0;
            end else if (!(has_pend && pend == rule[7:0])) begin
                repeat ($urandom_range(0, 3))
                    add_line_item({CMD_CHAR, other_than(rule[7:0])});
                add_line_item({CMD_CHAR, rule[7:0]});
                has_pend = 1'b1;
                pend = rule[7:0];
            end
        end
        repeat ($urandom_range(0, 3)) add_line_item({CMD_CHAR, 8'($urandom)});
    endtask

    task automatic run_random_lines(input int in_pct, input int out_pct, input int goal);
        int stop_at;
        int lines_left;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        stop_at = items_sent + goal;
        lines_left = 0;
        while (items_sent < stop_at) begin
            if (lines_left == 0) begin
                wait_idle();
                load_random_program();
                lines_left = $urandom_range(2, 5);
            end
            build_line();
            foreach (line_items[k]) send_item(line_items[k][8], line_items[k][7:0]);
            end_line();
            lines_left--;
        end
    endtask

    task automatic test_after_reset();
        in_idle_pct = 37;
        out_idle_pct = 53;
        end_line();
        send_item(CMD_CHAR, 8'hFF);
        send_item(CMD_CHAR, 8'h00);
        end_line();
    endtask

    task automatic test_rule_actions();
        wait_idle();
        load_program(5'd6,
            pack_rules(rule_code(rdlfe_pkg::ACT_SKIP, "G"),
                       rule_code(rdlfe_pkg::ACT_ANY, 8'h00),
                       rule_code(rdlfe_pkg::ACT_UPTO, ","),
                       rule_code(rdlfe_pkg::ACT_SKIP, ",")),
            pack_rules(rule_code(rdlfe_pkg::ACT_UPTO, ";"),
                       rule_code(rdlfe_pkg::ACT_SKIPTO, ";"), '0, '0),
            '0, '0);
        send_text("GxAB,C;Z");
        end_line();
        send_text("H");
        end_line();
        send_text("G");
        end_line();
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // oversized count acts as a full program of zero-char captures
        load_program(5'd31, '0, '0, '0, '0);
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_UNUSED + 3'd1, '1);
        write_reg(CFG_UNUSED + 3'd2, '1);
        send_item(CMD_CHAR, "x");
        send_item(CMD_CHAR, 8'h00);
        end_line();
        wait_idle();
        load_program(5'd17, '1, '1, '1, '1);
        send_text("abc");
        end_line();
    endtask

    task automatic test_random_slow_sink();
        run_random_lines(37, 53, 125);
    endtask

    task automatic test_random_slow_source();
        run_random_lines(53, 37, 125);
    endtask

    task automatic test_random_full_rate();
        run_random_lines(0, 0, 125);
    endtask

    initial begin
        foreach (cfg_words[w]) cfg_words[w] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_rule_actions();
        test_register_extremes();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();
        wait_idle();

        $display("tb_top: %0d input transactions, %0d fields captured", items_sent, n_fields);
        $display("tb_top: %0d lines accepted, %0d rejected, %0d mismatches",
                 n_accepts, n_rejects, errors);
        if (errors == 0 && due_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
